>>> hdl/shpf_pkg.sv
package shpf_pkg;

	// Link byte codes and frame constants.
	localparam logic [7:0] START_BYTE  = 8'h9B;
	localparam logic [7:0] END_BYTE    = 8'h9D;
	localparam logic [7:0] HEIGHT_KIND = 8'h12;
	localparam logic [7:0] HEIGHT_LEN  = 8'd7;
	localparam int unsigned POINT_IDX  = 7;
	localparam logic [3:0] HYPHEN_CODE = 4'd10;

	localparam int unsigned HEIGHT_W = 14;
	localparam int unsigned HIST_DEPTH = 5;

	typedef logic [HEIGHT_W-1:0] height_t;

	// One result from the parser toward the output register.
	typedef struct packed {
		logic    hit;
		height_t height;
	} result_t;

	// Seven-segment decode of bits 6..0; the decimal point is ignored here.
	function automatic logic [3:0] seg_digit(input logic [7:0] pat);
		logic [3:0] d;
		begin
			unique case (pat[6:0])
				7'h3F: d = 4'd0;
				7'h06: d = 4'd1;
				7'h5B: d = 4'd2;
				7'h4F: d = 4'd3;
				7'h66: d = 4'd4;
				7'h6D: d = 4'd5;
				7'h7D: d = 4'd6;
				7'h07: d = 4'd7;
				7'h7F: d = 4'd8;
				7'h6F: d = 4'd9;
				7'h40: d = HYPHEN_CODE;
				default: d = 4'd0;
			endcase
			return d;
		end
	endfunction

endpackage

>>> hdl/seven_segment_height_frame_parser_core.sv
// Path: an accepted byte waits in the input register; when it ends a frame with a new height,
// it sets m_tvalid from the result register once that register is free.
// Throughput: one byte per cycle while no result waits; while a result waits, one more request is
// taken into the input register and then s_tready drops until the result is taken.
// Reset: arst_n clears the byte history, frame state, held and published heights, and
// both valid flags at once; the block is ready for bytes as soon as reset is released.
module seven_segment_height_frame_parser_core import shpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [13:0] height_tenths, [15:14] zero
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	height_t    height_q;
	logic       out_free;
	logic       s1_fire;
	result_t    result;

	assign out_free = !out_valid_q || m_tready;
	assign s1_fire = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	shpf_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (s1_fire),
		.rx_byte (byte_s1),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= result.hit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && result.hit) begin
			height_q <= result.height;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, height_q};

endmodule

>>> hdl/shpf_parse.sv
module shpf_parse import shpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] rx_byte,
	output result_t    result
);

	logic [7:0] hist_q [HIST_DEPTH];
	logic [7:0] frame_length_q;
	logic [7:0] frame_kind_q;
	logic       frame_good_q;
	height_t    current_height_q;
	height_t    published_height_q;

	logic [7:0] len_n;
	logic [7:0] kind_n;
	logic       good_n;
	height_t    cur_n;
	logic [3:0] d_hi;
	logic [3:0] d_mid;
	logic [3:0] d_lo;
	logic [10:0] sum_units;
	height_t    sum_tenths;

	// Digit decode of a height frame: hundreds, tens, then the incoming units byte.
	always_comb begin
		d_hi = seg_digit(hist_q[1]);
		d_mid = seg_digit(hist_q[0]);
		d_lo = seg_digit(rx_byte);
		sum_units = 11'(d_hi) * 11'd100 + 11'(d_mid) * 11'd10 + 11'(d_lo);
		if (hist_q[0][POINT_IDX]) begin
			sum_tenths = HEIGHT_W'(sum_units);
		end else begin
			sum_tenths = HEIGHT_W'(sum_units) * HEIGHT_W'(10);
		end
	end

	// Frame tracking in the order the link protocol checks positions.
	always_comb begin
		len_n = frame_length_q;
		kind_n = frame_kind_q;
		good_n = frame_good_q;
		cur_n = current_height_q;
		if (rx_byte == START_BYTE) begin
			len_n = '0;
			good_n = 1'b0;
		end
		if (hist_q[0] == START_BYTE) begin
			len_n = rx_byte;
		end
		if (hist_q[1] == START_BYTE) begin
			kind_n = rx_byte;
		end
		if (hist_q[2] == START_BYTE && kind_n == HEIGHT_KIND && len_n == HEIGHT_LEN
				&& rx_byte != 8'd0) begin
			good_n = 1'b1;
		end
		if (hist_q[4] == START_BYTE && good_n && d_mid != HYPHEN_CODE) begin
			cur_n = sum_tenths;
		end
	end

	// Publish on the end byte when the height is new and nonzero.
	assign result.hit = (rx_byte == END_BYTE) && (cur_n != '0) && (cur_n != published_height_q);
	assign result.height = cur_n;

	// State update once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			frame_length_q <= '0;
			frame_kind_q <= '0;
			frame_good_q <= 1'b0;
			current_height_q <= '0;
			published_height_q <= '0;
		end else if (step_en) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= rx_byte;
			frame_length_q <= len_n;
			frame_kind_q <= kind_n;
			frame_good_q <= good_n;
			current_height_q <= cur_n;
			if (result.hit) begin
				published_height_q <= cur_n;
			end
		end
	end

endmodule
